// ----- sv/ioct_pkg.sv -----
package ioct_pkg;

    // Ring geometry.
    localparam int RING_DEPTH = 4096;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    // Beat field widths.
    localparam int ID_W    = 63;
    localparam int ENTRY_W = ID_W + 1;
    localparam int RET_W   = 13;

    // Kind of an input beat.
    localparam logic KIND_ISSUE    = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ISSUED    = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_NOT_HEAD  = 3'd2,
        ST_COMMITTED = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    append;
        logic    clr_k;
        logic    rd_en;
        logic    mark;
        logic    commit;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic hit;
        logic more;
        logic at_head;
        logic ret_end;
    } t_dp_stat;

endpackage

// ----- sv/ioct_ctrl.sv -----
module ioct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_kind,
    input  ioct_pkg::t_dp_stat i_stat,
    output ioct_pkg::t_dp_cmd  o_cmd,
    output logic              busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_MARK,
        S_RETIRE
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and per-cycle commands.
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.out_status = ioct_pkg::ST_ISSUED;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_kind == ioct_pkg::KIND_ISSUE) begin
                        o_cmd.out_load = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.out_status = ioct_pkg::ST_REJECTED;
                        end else begin
                            o_cmd.append     = 1'b1;
                            o_cmd.out_status = ioct_pkg::ST_ISSUED;
                        end
                    end else begin
                        o_cmd.capture = 1'b1;
                        o_cmd.clr_k   = 1'b1;
                        n_state       = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // Scan from the head for the oldest live entry with this id.
                if (i_stat.hit) begin
                    n_state = S_MARK;
                end else if (i_stat.more) begin
                    o_cmd.rd_en = 1'b1;
                end else begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ioct_pkg::ST_UNKNOWN;
                    n_state          = S_IDLE;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_stat.at_head) begin
                    o_cmd.clr_k = 1'b1;
                    n_state     = S_RETIRE;
                end else begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ioct_pkg::ST_NOT_HEAD;
                    n_state          = S_IDLE;
                end
            end
            S_RETIRE: begin
                // Walk the run of done entries from the head.
                if (i_stat.ret_end) begin
                    o_cmd.commit     = 1'b1;
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ioct_pkg::ST_COMMITTED;
                    n_state          = S_IDLE;
                end else if (i_stat.more) begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- sv/ioct_dp.sv -----
module ioct_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [ioct_pkg::ID_W-1:0]           i_tx_id,
    input  ioct_pkg::t_dp_cmd                   i_cmd,
    output ioct_pkg::t_dp_stat                  o_stat,
    output logic                                o_valid,
    output logic [2:0]                          o_status,
    output logic [ioct_pkg::ID_W-1:0]           o_commit_pointer,
    output logic [ioct_pkg::RET_W-1:0]          o_retired_count,
    output logic                                o_ring_full
);

    // Entry store: bit ID_W is the done flag, the rest is the id.
    logic [ioct_pkg::ENTRY_W-1:0] r_mem [ioct_pkg::RING_DEPTH];

    logic [ioct_pkg::IDX_W-1:0]   r_head;
    logic [ioct_pkg::CNT_W-1:0]   r_occ;
    logic [ioct_pkg::CNT_W-1:0]   n_occ;
    logic [ioct_pkg::CNT_W-1:0]   r_k;
    logic [ioct_pkg::IDX_W-1:0]   r_rk;
    logic                         r_rv;
    logic [ioct_pkg::ENTRY_W-1:0] r_rdata;
    logic [ioct_pkg::ID_W-1:0]    r_id;
    logic                         r_valid;
    logic [2:0]                   r_status;
    logic [ioct_pkg::ID_W-1:0]    r_ptr;
    logic [ioct_pkg::RET_W-1:0]   r_ret;
    logic                         r_full;

    logic [ioct_pkg::IDX_W-1:0]   rd_addr;
    logic [ioct_pkg::IDX_W-1:0]   wr_addr;
    logic [ioct_pkg::CNT_W-1:0]   run;
    logic [ioct_pkg::ID_W-1:0]    ptr;
    logic                         rd_done;

    // Ring position of an offset from the head; the sum stays below twice the depth.
    function automatic logic [ioct_pkg::IDX_W-1:0] ring_pos(
        input logic [ioct_pkg::IDX_W-1:0] head,
        input logic [ioct_pkg::CNT_W-1:0] off
    );
        logic [ioct_pkg::SUM_W-1:0] sum;
        sum = ioct_pkg::SUM_W'(head) + ioct_pkg::SUM_W'(off);
        if (sum >= ioct_pkg::SUM_W'(ioct_pkg::RING_DEPTH)) begin
            sum = sum - ioct_pkg::SUM_W'(ioct_pkg::RING_DEPTH);
        end
        return sum[ioct_pkg::IDX_W-1:0];
    endfunction

    // Addresses, status and commit values.
    always_comb begin
        rd_addr = ring_pos(r_head, r_k);
        if (i_cmd.append) begin
            wr_addr = ring_pos(r_head, r_occ);
        end else begin
            wr_addr = ring_pos(r_head, ioct_pkg::CNT_W'(r_rk));
        end

        rd_done = r_rdata[ioct_pkg::ENTRY_W-1];

        o_stat.full    = (r_occ == ioct_pkg::CNT_W'(ioct_pkg::RING_DEPTH));
        o_stat.hit     = r_rv && (r_rdata == {1'b0, r_id});
        o_stat.more    = (r_k < r_occ);
        o_stat.at_head = (r_rk == '0);
        o_stat.ret_end = r_rv && (!rd_done || !o_stat.more);

        // A done entry ending the walk means every entry was retired.
        if (rd_done) begin
            run = r_occ;
            ptr = r_rdata[ioct_pkg::ID_W-1:0] + ioct_pkg::ID_W'(1);
        end else begin
            run = ioct_pkg::CNT_W'(r_rk);
            ptr = r_rdata[ioct_pkg::ID_W-1:0];
        end

        if (i_cmd.append) begin
            n_occ = r_occ + ioct_pkg::CNT_W'(1);
        end else if (i_cmd.commit) begin
            n_occ = r_occ - run;
        end else begin
            n_occ = r_occ;
        end
    end

    // Entry store write and read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[wr_addr] <= {1'b0, i_tx_id};
        end else if (i_cmd.mark) begin
            r_mem[wr_addr] <= {1'b1, r_id};
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_rk    <= r_k[ioct_pkg::IDX_W-1:0];
        end
    end

    // Ring pointers and scan counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_occ   <= '0;
            r_k     <= '0;
            r_rv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_occ   <= n_occ;
            r_rv    <= i_cmd.rd_en;
            r_valid <= i_cmd.out_load;
            if (i_cmd.commit) begin
                r_head <= ring_pos(r_head, run);
            end
            if (i_cmd.clr_k) begin
                r_k <= '0;
            end else if (i_cmd.rd_en) begin
                r_k <= r_k + ioct_pkg::CNT_W'(1);
            end
        end
    end

    // Captured id and result beat registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id <= i_tx_id;
        end
        if (i_cmd.out_load) begin
            r_status <= i_cmd.out_status;
            r_full   <= (n_occ == ioct_pkg::CNT_W'(ioct_pkg::RING_DEPTH));
            if (i_cmd.commit) begin
                r_ptr <= ptr;
                r_ret <= ioct_pkg::RET_W'(run);
            end else begin
                r_ptr <= '0;
                r_ret <= '0;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_commit_pointer = r_ptr;
    assign o_retired_count  = r_ret;
    assign o_ring_full      = r_full;

endmodule

// ----- sv/in_order_commit_tracker.sv -----
// In-order commit tracker. An issue beat (i_kind 0) appends i_tx_id to a ring of
// RING_DEPTH entries; a completion beat (i_kind 1) marks the oldest live entry with
// that id done and, when it is the head, retires the run of done entries and reports
// the next commit pointer. A beat is taken when start is high and busy is low. Each
// beat gives exactly one result, shown for one cycle with o_valid high; the receiver
// cannot stall it, so it must take every result in that cycle. An issue beat gives its
// result on the next cycle and a new beat may be started at once. A completion beat
// scans the ring from the head through the single read port of the entry store, one
// entry a cycle, and when the head commits it also walks the run of done entries
// to retire them; busy stays high until the result is loaded, so no new beat is
// taken meanwhile. busy is low again in the cycle the result is shown.
module in_order_commit_tracker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_kind,
    input  logic [ioct_pkg::ID_W-1:0]  i_tx_id,
    output logic                       o_valid,
    output logic [2:0]                 o_status,
    output logic [ioct_pkg::ID_W-1:0]  o_commit_pointer,
    output logic [ioct_pkg::RET_W-1:0] o_retired_count,
    output logic                       o_ring_full
);

    ioct_pkg::t_dp_cmd  cmd;
    ioct_pkg::t_dp_stat stat;

    // Sequencer.
    ioct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Entry store, ring pointers and result registers.
    ioct_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tx_id          (i_tx_id),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_commit_pointer (o_commit_pointer),
        .o_retired_count  (o_retired_count),
        .o_ring_full      (o_ring_full)
    );

endmodule

// ----- dv/in_order_commit_tracker_tb.sv -----
module in_order_commit_tracker_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ioct_pkg::ID_W-1:0] ID_MAX      = '1;
    localparam logic [ioct_pkg::ID_W-1:0] ID_ODD_BITS = 63'h5555_5555_5555_5555;
    localparam logic [ioct_pkg::ID_W-1:0] ID_EVN_BITS = 63'h2AAA_AAAA_AAAA_AAAA;
    localparam int unsigned     RAND_BEATS  = 120;
    localparam int unsigned     RAND_CAP    = 20;
    localparam int unsigned     DRAIN_LIMIT = 3 * ioct_pkg::RING_DEPTH + 100;

    // One expected result beat.
    typedef struct packed {
        ioct_pkg::t_status                status;
        logic [ioct_pkg::ID_W-1:0]        pointer;
        logic [ioct_pkg::RET_W-1:0]       retired;
        logic                             full;
    } t_commit_result;

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        logic                             kind;
        logic [ioct_pkg::ID_W-1:0]        id;
        logic                             typed;
        t_commit_result                   want;
    } t_dir_row;

    localparam t_commit_result NONE_TYPED = '{ioct_pkg::ST_ISSUED, '0, '0, 1'b0};
    localparam t_commit_result ISSUED_OK  = '{ioct_pkg::ST_ISSUED, '0, '0, 1'b0};
    localparam t_commit_result UNKNOWN_ID = '{ioct_pkg::ST_UNKNOWN, '0, '0, 1'b0};

    localparam int DIR_ROWS = 20;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{ioct_pkg::KIND_COMPLETE, 63'd5,          1'b1, UNKNOWN_ID},
        '{ioct_pkg::KIND_ISSUE,    63'd0,          1'b1, ISSUED_OK},
        '{ioct_pkg::KIND_ISSUE,    ID_MAX,         1'b1, ISSUED_OK},
        '{ioct_pkg::KIND_COMPLETE, ID_MAX,         1'b1,
          '{ioct_pkg::ST_NOT_HEAD, '0, '0, 1'b0}},
        '{ioct_pkg::KIND_COMPLETE, 63'd0,          1'b1,
          '{ioct_pkg::ST_COMMITTED, '0, 13'd2, 1'b0}},
        '{ioct_pkg::KIND_ISSUE,    63'd10,         1'b1, ISSUED_OK},
        '{ioct_pkg::KIND_ISSUE,    63'd10,         1'b1, ISSUED_OK},
        '{ioct_pkg::KIND_ISSUE,    63'd11,         1'b1, ISSUED_OK},
        '{ioct_pkg::KIND_COMPLETE, 63'd10,         1'b0, NONE_TYPED},
        '{ioct_pkg::KIND_COMPLETE, 63'd11,         1'b0, NONE_TYPED},
        '{ioct_pkg::KIND_COMPLETE, 63'd11,         1'b1, UNKNOWN_ID},
        '{ioct_pkg::KIND_COMPLETE, 63'd10,         1'b0, NONE_TYPED},
        '{ioct_pkg::KIND_ISSUE,    ID_ODD_BITS,    1'b0, NONE_TYPED},
        '{ioct_pkg::KIND_ISSUE,    ID_EVN_BITS,    1'b0, NONE_TYPED},
        '{ioct_pkg::KIND_ISSUE,    63'd1,          1'b0, NONE_TYPED},
        '{ioct_pkg::KIND_COMPLETE, 63'd1,          1'b0, NONE_TYPED},
        '{ioct_pkg::KIND_COMPLETE, ID_EVN_BITS,    1'b0, NONE_TYPED},
        '{ioct_pkg::KIND_COMPLETE, ID_ODD_BITS,    1'b0, NONE_TYPED},
        '{ioct_pkg::KIND_ISSUE,    ID_MAX - 63'd1, 1'b0, NONE_TYPED},
        '{ioct_pkg::KIND_COMPLETE, ID_MAX - 63'd1, 1'b0, NONE_TYPED}
    };

    logic                              i_clk   = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start   = 1'b0;
    logic                              i_kind  = 1'b0;
    logic [ioct_pkg::ID_W-1:0]         i_tx_id = '0;
    logic                              busy;
    logic                              o_valid;
    logic [2:0]                        o_status;
    logic [ioct_pkg::ID_W-1:0]         o_commit_pointer;
    logic [ioct_pkg::RET_W-1:0]        o_retired_count;
    logic                              o_ring_full;

    // Shadow copy of the ring, kept in issue order.
    logic [ioct_pkg::ENTRY_W-1:0] ring_model [ioct_pkg::RING_DEPTH];
    int unsigned        ring_head;
    int unsigned        ring_occ;

    t_commit_result     pending_results [$];
    int unsigned        fail_count;
    int unsigned        results_seen;
    int unsigned        issue_beats;
    int unsigned        complete_beats;
    int unsigned        max_occ_seen;
    int unsigned        max_run_seen;
    int unsigned        status_seen [0:7];
    bit                 gaps_on;

    in_order_commit_tracker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_kind           (i_kind),
        .i_tx_id          (i_tx_id),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_commit_pointer (o_commit_pointer),
        .o_retired_count  (o_retired_count),
        .o_ring_full      (o_ring_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned ring_pos(input int unsigned offset);
        return (ring_head + offset) % ioct_pkg::RING_DEPTH;
    endfunction

    function automatic logic [ioct_pkg::ID_W-1:0] entry_id(input int unsigned offset);
        return ring_model[ring_pos(offset)][ioct_pkg::ID_W-1:0];
    endfunction

    // Applies one accepted beat to the shadow ring and returns its result.
    function automatic t_commit_result track_commit(input logic kind,
                                                    input logic [ioct_pkg::ID_W-1:0] id);
        t_commit_result               res;
        int unsigned                  k;
        int unsigned                  found;
        int unsigned                  run;
        bit                           hit;
        logic [ioct_pkg::ENTRY_W-1:0] marked;
        res     = '{ioct_pkg::ST_ISSUED, '0, '0, 1'b0};
        hit     = 1'b0;
        found   = 0;
        if (kind == ioct_pkg::KIND_ISSUE) begin
            if (ring_occ >= ioct_pkg::RING_DEPTH) begin
                res.status = ioct_pkg::ST_REJECTED;
            end else begin
                ring_model[ring_pos(ring_occ)] = {1'b0, id};
                ring_occ++;
            end
        end else begin
            // The oldest live entry with this id takes the completion.
            for (k = 0; k < ring_occ && !hit; k++) begin
                if (ring_model[ring_pos(k)] == {1'b0, id}) begin
                    found = k;
                    hit   = 1'b1;
                end
            end
            if (!hit) begin
                res.status = ioct_pkg::ST_UNKNOWN;
            end else begin
                marked = {1'b1, id};
                ring_model[ring_pos(found)] = marked;
                if (marked != ring_model[ring_head]) begin
                    res.status = ioct_pkg::ST_NOT_HEAD;
                end else begin
                    // Retire the run of done entries from the head.
                    run = 0;
                    while (run < ring_occ && ring_model[ring_pos(run)][ioct_pkg::ID_W])
                        run++;
                    if (run == ring_occ)
                        res.pointer = entry_id(run - 1) + 1'b1;
                    else
                        res.pointer = entry_id(run);
                    ring_head   = ring_pos(run);
                    ring_occ    = ring_occ - run;
                    res.retired = ioct_pkg::RET_W'(run);
                    res.status  = ioct_pkg::ST_COMMITTED;
                    if (run > max_run_seen)
                        max_run_seen = run;
                end
            end
        end
        res.full = (ring_occ >= ioct_pkg::RING_DEPTH);
        if (ring_occ > max_occ_seen)
            max_occ_seen = ring_occ;
        return res;
    endfunction

    // Mostly full-width ids, with a small pool and values near the top for duplicates.
    function automatic logic [ioct_pkg::ID_W-1:0] rand_id();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1: return ioct_pkg::ID_W'($urandom_range(3));
            2: return ID_MAX - ioct_pkg::ID_W'($urandom_range(3));
            default: return wide[ioct_pkg::ID_W-1:0];
        endcase
    endfunction

    // Completions mostly name an entry in the ring, the head often.
    function automatic logic [ioct_pkg::ID_W-1:0] pick_complete_id();
        int unsigned offset;
        if (ring_occ == 0 || $urandom_range(99) < 15)
            return rand_id();
        offset = ($urandom_range(99) < 30) ? 0 : $urandom_range(ring_occ - 1);
        return entry_id(offset);
    endfunction

    // Drives one beat, waits for it to be taken and queues its expected result.
    task automatic send_beat(input logic kind, input logic [ioct_pkg::ID_W-1:0] id,
                             input logic typed = 1'b0,
                             input t_commit_result want = NONE_TYPED);
        t_commit_result res;
        if (gaps_on && $urandom_range(99) < 30) begin
            start   <= 1'b0;
            i_kind  <= 1'($urandom);
            i_tx_id <= rand_id();
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_kind  <= kind;
        i_tx_id <= id;
        do @(posedge i_clk); while (busy !== 1'b0);
        res = track_commit(kind, id);
        if (typed)
            res = want;
        pending_results = {pending_results, res};
        if (kind == ioct_pkg::KIND_ISSUE)
            issue_beats++;
        else
            complete_beats++;
    endtask

    // Holds the sender off until every queued result has come back.
    task automatic wait_results_done();
        int unsigned n;
        n = 0;
        start <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (pending_results.size() != 0 && n < DRAIN_LIMIT);
    endtask

    // Every result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_commit_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            results_seen++;
            status_seen[o_status]++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("[%0t] unexpected result beat: status %0d pointer %h",
                             $realtime, o_status, o_commit_pointer);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_commit_pointer !== want.pointer ||
                    o_retired_count !== want.retired || o_ring_full !== want.full) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("[%0t] result mismatch (expected/actual):", $realtime);
                        $display("    status %0d/%0d pointer %h/%h retired %0d/%0d full %0b/%0b",
                                 want.status, o_status, want.pointer, o_commit_pointer,
                                 want.retired, o_retired_count, want.full, o_ring_full);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned     n;
        ring_head      = 0;
        ring_occ       = 0;
        fail_count     = 0;
        results_seen   = 0;
        issue_beats    = 0;
        complete_beats = 0;
        max_occ_seen   = 0;
        max_run_seen   = 0;
        gaps_on        = 1'b1;
        foreach (status_seen[s])
            status_seen[s] = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: extremes, duplicates, wrap of the commit pointer.
        for (n = 0; n < DIR_ROWS; n++)
            send_beat(DIR_TABLE[n].kind, DIR_TABLE[n].id, DIR_TABLE[n].typed,
                      DIR_TABLE[n].want);
        wait_results_done();

        // Random traffic over a shallow ring, with one stretch of back-to-back beats.
        for (n = 0; n < RAND_BEATS; n++) begin
            gaps_on = !(n >= 50 && n < 90);
            if (ring_occ >= RAND_CAP || (ring_occ != 0 && $urandom_range(1)))
                send_beat(ioct_pkg::KIND_COMPLETE, pick_complete_id());
            else if (ring_occ == 0 && $urandom_range(9) == 0)
                send_beat(ioct_pkg::KIND_COMPLETE, rand_id());
            else
                send_beat(ioct_pkg::KIND_ISSUE, rand_id());
        end
        gaps_on = 1'b1;

        wait_results_done();
        repeat (2 * ioct_pkg::RING_DEPTH + 8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            fail_count += pending_results.size();
            $display("%0d expected result beats never arrived", pending_results.size());
        end

        $display("Covered %0d issue and %0d completion beats, %0d results; ring peaked at %0d",
                 issue_beats, complete_beats, results_seen, max_occ_seen);
        $display("  entries, longest retire run %0d; status counts %0d/%0d/%0d/%0d/%0d.",
                 max_run_seen, status_seen[ioct_pkg::ST_ISSUED],
                 status_seen[ioct_pkg::ST_REJECTED], status_seen[ioct_pkg::ST_NOT_HEAD],
                 status_seen[ioct_pkg::ST_COMMITTED], status_seen[ioct_pkg::ST_UNKNOWN]);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop well past the slowest correct run.
    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ioct_pkg.sv
sv/ioct_ctrl.sv
sv/ioct_dp.sv
sv/in_order_commit_tracker.sv
dv/in_order_commit_tracker_tb.sv
